/* design/tal_pkg.sv */
// Package for the tree ancestor / LCA engine.
// Sizes, transaction types, memory request structs and address helpers.
// No dependencies.
package tal_pkg;

  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = 10;
  localparam int DEP_W     = 10;
  localparam int LEN_W     = 11;
  localparam int NODE_AW   = $clog2(NODES);
  localparam int TAB_DEPTH = NODES * LEVELS;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [DEP_W-1:0] DEPTH_MAX = {DEP_W{1'b1}};

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor_node;
    logic [LEN_W-1:0]  path_length;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [TAB_AW-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic [TAB_AW-1:0] raddr_a;
    logic [TAB_AW-1:0] raddr_b;
  } tab_req_t;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    logic [DEP_W-1:0]   wdata;
    logic [NODE_AW-1:0] raddr_a;
    logic [NODE_AW-1:0] raddr_b;
  } dep_req_t;

  function automatic logic [NODE_W-1:0] clip_node(input logic [NODE_W-1:0] n);
    return (int'(n) < NODES) ? n : '0;
  endfunction

  function automatic logic [NODE_AW-1:0] dep_addr(input logic [NODE_W-1:0] n);
    return NODE_AW'(n);
  endfunction

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [NODE_W-1:0] n,
                                                 input logic [LVL_W-1:0] lvl);
    return TAB_AW'(TAB_AW'(n) * TAB_AW'(LEVELS) + TAB_AW'(lvl));
  endfunction

endpackage

/* design/tree_ancestor_lca_engine_unit.sv */
// Binary-lifting ancestor table and lowest-common-ancestor engine.
// Depends on tal_pkg, tal_ram, tal_seq.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): req_type 0 inserts node_a under
//   parent node_b (0 = root) and produces no result; req_type 1 queries the
//   lowest common ancestor of node_a and node_b.
//   out channel (out_valid/out_ready/out_data): one transaction per query,
//   carrying ancestor_node and path_length (edges between the two nodes).
//   Inserts must come in parent-before-child order.
// Timing:
//   One transaction at a time; in_ready is low while it is processed.
//   Insert: a depth read, then one table read and one write per level.
//   Query: equal nodes go straight to the result; else a depth read, a table
//   read per set bit of the depth gap, a jump search over all levels unless
//   the lift meets the other node; without stalls out_valid rises with in_ready.
// Reset: clears control state only; the sentinel node 0 is hardwired to
//   depth 0 and ancestor 0, other table entries hold nothing until inserted.
// Stall: a result waits in the output register; the next transaction is
//   taken meanwhile, and a later result holds the sequencer until it drains.
module tree_ancestor_lca_engine_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tal_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output tal_pkg::res_t out_data
);
  import tal_pkg::*;

  tab_req_t          tab_req;
  dep_req_t          dep_req;
  logic [NODE_W-1:0] tab_rdata_a, tab_rdata_b;
  logic [DEP_W-1:0]  dep_rdata_a, dep_rdata_b;
  logic              slot_free;
  logic              res_valid;
  res_t              res;

  assign slot_free = !out_valid || out_ready;

  tal_ram #(
    .DEPTH (TAB_DEPTH),
    .WIDTH (NODE_W),
    .AW    (TAB_AW)
  ) u_tab (
    .clk     (clk),
    .we      (tab_req.we),
    .waddr   (tab_req.waddr),
    .wdata   (tab_req.wdata),
    .raddr_a (tab_req.raddr_a),
    .raddr_b (tab_req.raddr_b),
    .rdata_a (tab_rdata_a),
    .rdata_b (tab_rdata_b)
  );

  tal_ram #(
    .DEPTH (NODES),
    .WIDTH (DEP_W),
    .AW    (NODE_AW)
  ) u_dep (
    .clk     (clk),
    .we      (dep_req.we),
    .waddr   (dep_req.waddr),
    .wdata   (dep_req.wdata),
    .raddr_a (dep_req.raddr_a),
    .raddr_b (dep_req.raddr_b),
    .rdata_a (dep_rdata_a),
    .rdata_b (dep_rdata_b)
  );

  tal_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .tab_req     (tab_req),
    .tab_rdata_a (tab_rdata_a),
    .tab_rdata_b (tab_rdata_b),
    .dep_req     (dep_req),
    .dep_rdata_a (dep_rdata_a),
    .dep_rdata_b (dep_rdata_b),
    .slot_free   (slot_free),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule

/* design/tal_ram.sv */
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module tal_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* design/tal_seq.sv */
// Sequencer and datapath of the LCA engine: insert row build, depth
// equalize, binary-lifting search, path length. Depends on tal_pkg.
module tal_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tal_pkg::req_t                 in_data,
  output tal_pkg::tab_req_t             tab_req,
  input  logic [tal_pkg::NODE_W-1:0]    tab_rdata_a,
  input  logic [tal_pkg::NODE_W-1:0]    tab_rdata_b,
  output tal_pkg::dep_req_t             dep_req,
  input  logic [tal_pkg::DEP_W-1:0]     dep_rdata_a,
  input  logic [tal_pkg::DEP_W-1:0]     dep_rdata_b,
  input  logic                          slot_free,
  output logic                          res_valid,
  output tal_pkg::res_t                 res
);
  import tal_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IDEP = 4'd1;
  localparam logic [3:0] S_IRD  = 4'd2;
  localparam logic [3:0] S_IWR  = 4'd3;
  localparam logic [3:0] S_QDEP = 4'd4;
  localparam logic [3:0] S_LIFT = 4'd5;
  localparam logic [3:0] S_LWT  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_JRD  = 4'd8;
  localparam logic [3:0] S_JCMP = 4'd9;
  localparam logic [3:0] S_FRD  = 4'd10;
  localparam logic [3:0] S_FWT  = 4'd11;
  localparam logic [3:0] S_LEN  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LEVELS - 1);

  logic [3:0]        state, state_next;
  logic [LVL_W-1:0]  lvl, lvl_next;
  logic [NODE_W-1:0] cur, cur_next;
  logic [NODE_W-1:0] mid, mid_next;
  logic [NODE_W-1:0] u, u_next;
  logic [NODE_W-1:0] v, v_next;
  logic [LEVELS-1:0] diff, diff_next;
  logic [LEN_W-1:0]  dsum, dsum_next;
  res_t              res_next;

  // zero flags: node 0 rows are never written and read as zero
  logic              zta, ztb, zda, zdb;
  logic [NODE_W-1:0] tna, tnb, dna, dnb;
  logic [LVL_W-1:0]  tla, tlb;

  logic [NODE_W-1:0] ta, tb;
  logic [DEP_W-1:0]  da, db;
  logic [NODE_W-1:0] qa, qb;
  logic [DEP_W:0]    dinc;
  logic [LEN_W-1:0]  two_da;

  assign ta = zta ? '0 : tab_rdata_a;
  assign tb = ztb ? '0 : tab_rdata_b;
  assign da = zda ? '0 : dep_rdata_a;
  assign db = zdb ? '0 : dep_rdata_b;
  assign qa = clip_node(in_data.node_a);
  assign qb = clip_node(in_data.node_b);
  assign dinc   = {1'b0, da} + (DEP_W+1)'(1);
  assign two_da = {da, 1'b0};

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && slot_free;

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    cur_next   = cur;
    mid_next   = mid;
    u_next     = u;
    v_next     = v;
    diff_next  = diff;
    dsum_next  = dsum;
    res_next   = res;
    tna = '0;
    tnb = '0;
    tla = '0;
    tlb = '0;
    dna = '0;
    dnb = '0;
    tab_req.we    = 1'b0;
    tab_req.waddr = tab_addr(cur, lvl);
    tab_req.wdata = mid;
    dep_req.we    = 1'b0;
    dep_req.waddr = dep_addr(cur);
    dep_req.wdata = (dinc > (DEP_W+1)'(DEPTH_MAX)) ? DEPTH_MAX : dinc[DEP_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_INSERT) begin
            if (in_data.node_a != '0 && int'(in_data.node_a) < NODES) begin
              cur_next      = in_data.node_a;
              mid_next      = qb;
              lvl_next      = LVL_W'(1);
              tab_req.we    = 1'b1;
              tab_req.waddr = tab_addr(in_data.node_a, '0);
              tab_req.wdata = qb;
              dna           = qb;
              state_next    = S_IDEP;
            end
          end else begin
            u_next = qa;
            v_next = qb;
            if (qa == qb) begin
              res_next.ancestor_node = qa;
              res_next.path_length   = '0;
              state_next             = S_DONE;
            end else begin
              dna        = qa;
              dnb        = qb;
              state_next = S_QDEP;
            end
          end
        end
      end
      S_IDEP: begin
        dep_req.we = 1'b1;
        if (LEVELS == 1) begin
          state_next = S_IDLE;
        end else begin
          tna        = mid;
          tla        = lvl - LVL_W'(1);
          state_next = S_IWR;
        end
      end
      S_IRD: begin
        tna        = mid;
        tla        = lvl - LVL_W'(1);
        state_next = S_IWR;
      end
      S_IWR: begin
        tab_req.we    = 1'b1;
        tab_req.wdata = ta;
        mid_next      = ta;
        if (lvl == LVL_TOP) begin
          state_next = S_IDLE;
        end else begin
          lvl_next   = lvl + LVL_W'(1);
          state_next = S_IRD;
        end
      end
      S_QDEP: begin
        dsum_next = LEN_W'(da) + LEN_W'(db);
        if (da < db) begin
          u_next    = v;
          v_next    = u;
          diff_next = LEVELS'(db - da);
        end else begin
          diff_next = LEVELS'(da - db);
        end
        lvl_next   = LVL_TOP;
        state_next = S_LIFT;
      end
      S_LIFT: begin
        if (diff[lvl]) begin
          tna        = u;
          tla        = lvl;
          state_next = S_LWT;
        end else if (lvl == '0) begin
          state_next = S_CHK;
        end else begin
          lvl_next = lvl - LVL_W'(1);
        end
      end
      S_LWT: begin
        u_next = ta;
        if (lvl == '0) begin
          state_next = S_CHK;
        end else begin
          lvl_next   = lvl - LVL_W'(1);
          state_next = S_LIFT;
        end
      end
      S_CHK: begin
        if (u == v) begin
          res_next.ancestor_node = u;
          dna                    = u;
          state_next             = S_LEN;
        end else begin
          lvl_next   = LVL_TOP;
          tna        = u;
          tla        = LVL_TOP;
          tnb        = v;
          tlb        = LVL_TOP;
          state_next = S_JCMP;
        end
      end
      S_JRD: begin
        tna        = u;
        tla        = lvl;
        tnb        = v;
        tlb        = lvl;
        state_next = S_JCMP;
      end
      S_JCMP: begin
        if (ta != tb) begin
          u_next = ta;
          v_next = tb;
        end
        if (lvl == '0) begin
          state_next = S_FRD;
        end else begin
          lvl_next   = lvl - LVL_W'(1);
          state_next = S_JRD;
        end
      end
      S_FRD: begin
        tna        = u;
        tla        = '0;
        state_next = S_FWT;
      end
      S_FWT: begin
        res_next.ancestor_node = ta;
        dna                    = ta;
        state_next             = S_LEN;
      end
      S_LEN: begin
        res_next.path_length = (dsum < two_da) ? '0 : dsum - two_da;
        state_next           = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    tab_req.raddr_a = tab_addr(tna, tla);
    tab_req.raddr_b = tab_addr(tnb, tlb);
    dep_req.raddr_a = dep_addr(dna);
    dep_req.raddr_b = dep_addr(dnb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    lvl  <= lvl_next;
    cur  <= cur_next;
    mid  <= mid_next;
    u    <= u_next;
    v    <= v_next;
    diff <= diff_next;
    dsum <= dsum_next;
    res  <= res_next;
    zta  <= (tna == '0);
    ztb  <= (tnb == '0);
    zda  <= (dna == '0);
    zdb  <= (dnb == '0);
  end

endmodule
